### src/mwce_pkg.sv
// shared widths, operation and register codes, and the cell control bundle
`default_nettype none
package mwce_pkg;

   localparam int OFS_W  = 11;  // signed drop offset held by a cell
   localparam int CNT_W  = 9;   // column_count register
   localparam int HGT_W  = 10;  // screen_height register
   localparam int ROW_W  = 10;
   localparam int COL_W  = 8;
   localparam int RND_W  = 8;
   localparam int TCK_W  = 4;
   localparam int OP_W   = 2;
   localparam int SEED_W = 5;   // unscaled seed, -15..0
   localparam int CSR_W  = 10;
   localparam int IDX_W  = 11;  // common width for column index compares

   localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
   localparam logic [OP_W-1:0] OP_TICK  = 2'd1;
   localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

   localparam logic CSR_COLUMN_COUNT  = 1'b0;
   localparam logic CSR_SCREEN_HEIGHT = 1'b1;

   typedef struct packed {
      logic             step;
      logic [CNT_W-1:0] count;
      logic [HGT_W-1:0] height;
   } mwce_ctrl_type;

endpackage
`default_nettype wire

### src/mwce_cell.sv
// one ring cell: holds one column offset and its tag, applies a melt step on the way through
`default_nettype none
module mwce_cell
   import mwce_pkg::*;
#(
   parameter int TAG_W      = 8,
   parameter int CELL_INDEX = 0,
   parameter int SCALE      = 1
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire mwce_ctrl_type           ctrl,
   input  wire logic signed [OFS_W-1:0] nb_offset,
   input  wire logic [TAG_W-1:0]        nb_tag,
   output logic signed [OFS_W-1:0]      offset,
   output logic [TAG_W-1:0]             tag
);

   localparam int EXT_W = OFS_W + 1;
   localparam logic signed [EXT_W-1:0] STEP_S   = EXT_W'(SCALE);
   localparam logic signed [EXT_W-1:0] FAST_LIM = EXT_W'(16 * SCALE);
   localparam logic signed [EXT_W-1:0] SLOW_DY  = EXT_W'(8 * SCALE);

   logic signed [OFS_W-1:0] offset_ff, offset_in;
   logic [TAG_W-1:0]        tag_ff, tag_in;
   logic signed [EXT_W-1:0] y, h, dy, sum, moved_y;
   logic                    active;

   always_comb begin
      y      = {nb_offset[OFS_W-1], nb_offset};
      h      = {{(EXT_W-HGT_W){1'b0}}, ctrl.height};
      active = {{(IDX_W-TAG_W){1'b0}}, nb_tag} < {{(IDX_W-CNT_W){1'b0}}, ctrl.count};
      // accelerating drop until the fast limit, then a fixed drop
      dy  = (y < FAST_LIM) ? y + STEP_S : SLOW_DY;
      sum = y + dy;
      if (y < 0) begin
         moved_y = y + STEP_S;
      end else if (y < h) begin
         moved_y = (sum >= h) ? h : sum;
      end else begin
         moved_y = y;
      end
      offset_in = (ctrl.step && active) ? moved_y[OFS_W-1:0] : nb_offset;
      tag_in    = nb_tag;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= TAG_W'(CELL_INDEX);
      end else begin
         tag_ff <= tag_in;
      end
   end

   always_ff @(posedge clock) begin
      offset_ff <= offset_in;
   end

   assign offset = offset_ff;
   assign tag    = tag_ff;

endmodule
`default_nettype wire

### src/melt_wipe_column_engine_unit.sv
// melt wipe column engine: rotating ring of column cells, sequencer and result register
//
//   port group | dir  | handshake          | contents
//   req_*      | in   | req_valid/req_stall | op, column, row, random_byte, tick_count
//   rsp_*      | out  | rsp_valid/rsp_stall | source_screen, source_row, done_res
//   csr_*      | in   | csr_write_en        | column_count (0), screen_height (1)
//
// the ring turns one cell per cycle; a load or query waits until its column reaches
// cell 0. a zero tick, an unused op or a column beyond the ring goes straight to finish;
// other ticks sweep the whole ring to look for moving columns, then step every column in
// use at once tick_count times, and then finish.
// reset restores cell tags and registers only; offsets are undefined until loaded. finish
// waits while a stalled result fills the output register; the next item is taken behind it.
`default_nettype none
module melt_wipe_column_engine_unit
   import mwce_pkg::*;
#(
   parameter int MAX_COLUMNS = 256,
   parameter int SCALE       = 1
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire logic [OP_W-1:0]  req_op,
   input  wire logic [COL_W-1:0] req_column,
   input  wire logic [ROW_W-1:0] req_row,
   input  wire logic [RND_W-1:0] req_random_byte,
   input  wire logic [TCK_W-1:0] req_tick_count,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output logic                  rsp_source_screen,
   output logic [ROW_W-1:0]      rsp_source_row,
   output logic                  rsp_done_res,
   input  wire logic             csr_write_en,
   input  wire logic             csr_index,
   input  wire logic [CSR_W-1:0] csr_data
);

   localparam int TAG_W = $clog2(MAX_COLUMNS);
   localparam logic [TAG_W-1:0] LAST_TAG = TAG_W'(MAX_COLUMNS - 1);
   localparam logic signed [OFS_W-1:0] SCALE_OFS = OFS_W'(SCALE);
   localparam logic signed [SEED_W:0] SEED_LO = -6'sd15;

   typedef enum logic [2:0] {S_IDLE, S_SEEK, S_SWEEP, S_STEP, S_FINISH} state_type;

   state_type               state_ff, state_in;
   logic [CNT_W-1:0]        column_count_ff, column_count_in;
   logic [HGT_W-1:0]        screen_height_ff, screen_height_in;
   logic signed [SEED_W-1:0] prev_seed_ff, prev_seed_in;
   logic [OP_W-1:0]         op_ff, op_in;
   logic [COL_W-1:0]        column_ff, column_in;
   logic [ROW_W-1:0]        row_ff, row_in;
   logic [TCK_W-1:0]        ticks_ff, ticks_in;
   logic signed [OFS_W-1:0] wval_ff, wval_in;
   logic [TAG_W-1:0]        sweep_ff, sweep_in;
   logic                    unsettled_ff, unsettled_in;
   logic                    pend_screen_ff, pend_screen_in;
   logic [ROW_W-1:0]        pend_row_ff, pend_row_in;
   logic                    pend_done_ff, pend_done_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_screen_ff, rsp_screen_in;
   logic [ROW_W-1:0]        rsp_row_ff, rsp_row_in;
   logic                    rsp_done_ff, rsp_done_in;

   logic signed [OFS_W-1:0] cell_offset [MAX_COLUMNS];
   logic [TAG_W-1:0]        cell_tag    [MAX_COLUMNS];
   logic signed [OFS_W-1:0] ring_offset [MAX_COLUMNS];
   logic [TAG_W-1:0]        ring_tag    [MAX_COLUMNS];
   mwce_ctrl_type           ctrl;

   logic                    wr_en, head_hit, head_active, req_in_range, rsp_free;
   logic signed [OFS_W:0]   head_y, height_x, row_x, query_diff;
   logic [1:0]              rnd_mod3;
   logic signed [SEED_W:0]  seed_sum;
   logic signed [SEED_W-1:0] seed_new;
   logic signed [OFS_W-1:0] seed_scaled;

   function automatic logic [1:0] mod3(input logic [RND_W-1:0] b);
      logic [3:0] s;
      logic [2:0] t;
      logic [2:0] u;
      // 4 is 1 mod 3, so base-4 digits can simply be summed
      s = 4'(b[1:0]) + 4'(b[3:2]) + 4'(b[5:4]) + 4'(b[7:6]);
      t = 3'(s[3:2]) + 3'(s[1:0]);
      u = 3'(t[2]) + 3'(t[1:0]);
      mod3 = (u >= 3'd3) ? 2'(u - 3'd3) : u[1:0];
   endfunction

   // ring of cells; the tail cell takes a load instead of cell 0 when written
   for (genvar p = 0; p < MAX_COLUMNS; p++) begin : g_cell
      if (p == MAX_COLUMNS - 1) begin : g_tail
         assign ring_offset[p] = wr_en ? wval_ff : cell_offset[0];
         assign ring_tag[p]    = cell_tag[0];
      end else begin : g_body
         assign ring_offset[p] = cell_offset[p+1];
         assign ring_tag[p]    = cell_tag[p+1];
      end
      mwce_cell #(
         .TAG_W      (TAG_W),
         .CELL_INDEX (p),
         .SCALE      (SCALE)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .nb_offset (ring_offset[p]),
         .nb_tag    (ring_tag[p]),
         .offset    (cell_offset[p]),
         .tag       (cell_tag[p])
      );
   end

   assign ctrl.step   = (state_ff == S_STEP);
   assign ctrl.count  = column_count_ff;
   assign ctrl.height = screen_height_ff;

   always_comb begin
      req_in_range = IDX_W'(req_column) < IDX_W'(MAX_COLUMNS);
      head_hit     = IDX_W'(cell_tag[0]) == IDX_W'(column_ff);
      head_active  = IDX_W'(cell_tag[0]) < IDX_W'(column_count_ff);
      head_y       = {cell_offset[0][OFS_W-1], cell_offset[0]};
      height_x     = {{(OFS_W+1-HGT_W){1'b0}}, screen_height_ff};
      row_x        = {{(OFS_W+1-ROW_W){1'b0}}, row_ff};
      query_diff   = row_x - ((head_y > 0) ? head_y : '0);
      wr_en        = (state_ff == S_SEEK) && (op_ff == OP_LOAD) && head_hit;
      rsp_free     = !rsp_valid_ff || !rsp_stall;

      rnd_mod3 = mod3(req_random_byte);
      seed_sum = {prev_seed_ff[SEED_W-1], prev_seed_ff} + {4'b0000, rnd_mod3} - 6'sd1;
      if (req_column == '0) begin
         seed_new = SEED_W'(0) - {1'b0, req_random_byte[3:0]};
      end else if (seed_sum > 0) begin
         seed_new = '0;
      end else if (seed_sum < SEED_LO) begin
         seed_new = SEED_LO[SEED_W-1:0];
      end else begin
         seed_new = seed_sum[SEED_W-1:0];
      end
      seed_scaled = {{(OFS_W-SEED_W){seed_new[SEED_W-1]}}, seed_new} * SCALE_OFS;
   end

   always_comb begin
      state_in         = state_ff;
      column_count_in  = column_count_ff;
      screen_height_in = screen_height_ff;
      prev_seed_in     = prev_seed_ff;
      op_in            = op_ff;
      column_in        = column_ff;
      row_in           = row_ff;
      ticks_in         = ticks_ff;
      wval_in          = wval_ff;
      sweep_in         = sweep_ff;
      unsettled_in     = unsettled_ff;
      pend_screen_in   = pend_screen_ff;
      pend_row_in      = pend_row_ff;
      pend_done_in     = pend_done_ff;
      rsp_valid_in     = rsp_valid_ff;
      rsp_screen_in    = rsp_screen_ff;
      rsp_row_in       = rsp_row_ff;
      rsp_done_in      = rsp_done_ff;

      if (csr_write_en) begin
         case (csr_index)
            CSR_COLUMN_COUNT:  column_count_in  = csr_data[CNT_W-1:0];
            CSR_SCREEN_HEIGHT: screen_height_in = csr_data[HGT_W-1:0];
            default: ;
         endcase
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in          = req_op;
               column_in      = req_column;
               row_in         = req_row;
               ticks_in       = req_tick_count;
               pend_screen_in = 1'b0;
               pend_row_in    = '0;
               pend_done_in   = 1'b0;
               state_in       = S_FINISH;
               case (req_op)
                  OP_LOAD: begin
                     prev_seed_in = seed_new;
                     wval_in      = seed_scaled;
                     if (req_in_range) begin
                        state_in = S_SEEK;
                     end
                  end
                  OP_TICK: begin
                     if (req_tick_count == '0) begin
                        pend_done_in = 1'b1;
                     end else begin
                        sweep_in     = '0;
                        unsettled_in = 1'b0;
                        state_in     = S_SWEEP;
                     end
                  end
                  OP_QUERY: begin
                     if (req_in_range) begin
                        state_in = S_SEEK;
                     end else begin
                        pend_row_in = req_row;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_SEEK: begin
            if (head_hit) begin
               if (op_ff == OP_QUERY) begin
                  if (row_x < head_y) begin
                     pend_screen_in = 1'b1;
                     pend_row_in    = row_ff;
                  end else begin
                     pend_row_in = query_diff[ROW_W-1:0];
                  end
               end
               state_in = S_FINISH;
            end
         end
         S_SWEEP: begin
            // a column in use that sits below the height will move in the first step
            if (head_active && (head_y < height_x)) begin
               unsettled_in = 1'b1;
            end
            if (sweep_ff == LAST_TAG) begin
               state_in = S_STEP;
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end
         S_STEP: begin
            ticks_in = ticks_ff - 1'b1;
            if (ticks_ff == TCK_W'(1)) begin
               pend_done_in = !unsettled_ff;
               state_in     = S_FINISH;
            end
         end
         S_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_screen_in = pend_screen_ff;
               rsp_row_in    = pend_row_ff;
               rsp_done_in   = pend_done_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         column_count_ff  <= CNT_W'(160);
         screen_height_ff <= HGT_W'(200);
         prev_seed_ff     <= '0;
         sweep_ff         <= '0;
         unsettled_ff     <= 1'b0;
         ticks_ff         <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         column_count_ff  <= column_count_in;
         screen_height_ff <= screen_height_in;
         prev_seed_ff     <= prev_seed_in;
         sweep_ff         <= sweep_in;
         unsettled_ff     <= unsettled_in;
         ticks_ff         <= ticks_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      op_ff          <= op_in;
      column_ff      <= column_in;
      row_ff         <= row_in;
      wval_ff        <= wval_in;
      pend_screen_ff <= pend_screen_in;
      pend_row_ff    <= pend_row_in;
      pend_done_ff   <= pend_done_in;
      rsp_screen_ff  <= rsp_screen_in;
      rsp_row_ff     <= rsp_row_in;
      rsp_done_ff    <= rsp_done_in;
   end

   assign req_stall         = (state_ff != S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_source_screen = rsp_screen_ff;
   assign rsp_source_row    = rsp_row_ff;
   assign rsp_done_res      = rsp_done_ff;

   // cell 1 always holds the column after cell 0's, wrapping after the last
   a_ring_order: assert property (@(posedge clock) disable iff (reset)
      cell_tag[1] == ((cell_tag[0] == LAST_TAG) ? '0 : TAG_W'(cell_tag[0] + 1'b1)))
      else $error("ring cells out of column order");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_FINISH))
      else $error("result raised outside finish");

   a_step_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_STEP) |-> (ticks_ff != '0))
      else $error("melt step with no steps left");

   a_rsp_one_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_done_ff && rsp_screen_ff))
      else $error("result carries both done and end screen");

endmodule
`default_nettype wire
